FILE: rtl/rcfs_pkg.sv
// Shared types, constants and register codes for the RC failsafe LED indicator.
package rcfs_pkg;

  // Widths of stored stick values and of the repeat counter
  localparam int CHANNEL_BITS = 12;
  localparam int COUNT_BITS   = 16;

  // Fixed field widths
  localparam int SW_BITS      = 12;
  localparam int LEVEL_BITS   = 8;
  localparam int MODE_BITS    = 2;
  localparam int CNT_OUT_BITS = 16;
  localparam int ELAPSED_BITS = 11;
  localparam int IVL_BITS     = 10;
  localparam int DELTA_BITS   = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DAT_BITS = 16;
  localparam int NUM_STICKS   = 4;

  // Compare width wide enough for counter and limit
  localparam int CMP_BITS = (COUNT_BITS > CNT_OUT_BITS) ? COUNT_BITS : CNT_OUT_BITS;

  localparam logic [LEVEL_BITS-1:0]   FULL_LEVEL  = '1;
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;

  // Register reset values
  localparam logic [DELTA_BITS-1:0]   RST_REPEAT_DELTA = 8'd5;
  localparam logic [SW_BITS-1:0]      RST_ARM_THR      = 12'd1250;
  localparam logic [SW_BITS-1:0]      RST_OVR_THR      = 12'd1250;
  localparam logic [CNT_OUT_BITS-1:0] RST_REPEAT_LIMIT = 16'd50000;
  localparam logic [IVL_BITS-1:0]     RST_INTERVAL     = 10'd50;
  localparam logic [LEVEL_BITS-1:0]   RST_FADE_STEP    = 8'd5;

  // Output codes of the LED mode
  localparam logic [MODE_BITS-1:0] MODE_CODE_FADE_IN  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_CODE_FADE_OUT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CODE_FAST     = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_CODE_ON       = 2'd3;

  // Item codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_REPEAT_DELTA = 3'd0,
    REG_ARM_THR      = 3'd1,
    REG_OVR_THR      = 3'd2,
    REG_REPEAT_LIMIT = 3'd3,
    REG_INTERVAL     = 3'd4,
    REG_FADE_STEP    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [DELTA_BITS-1:0]   repeat_delta;
    logic [SW_BITS-1:0]      arm_thr;
    logic [SW_BITS-1:0]      ovr_thr;
    logic [CNT_OUT_BITS-1:0] repeat_limit;
    logic [IVL_BITS-1:0]     interval;
    logic [LEVEL_BITS-1:0]   fade_step;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [SW_BITS-1:0] aileron;
    logic [SW_BITS-1:0] elevator;
    logic [SW_BITS-1:0] throttle;
    logic [SW_BITS-1:0] rudder;
    logic [SW_BITS-1:0] arm_switch;
    logic [SW_BITS-1:0] override_switch;
  } item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0]   led_level;
    logic [MODE_BITS-1:0]    led_mode;
    logic [CNT_OUT_BITS-1:0] repeat_count;
    logic                    led_updated;
  } res_t;

endpackage

FILE: rtl/rcfs_cfg_regs.sv
// Configuration register file of the RC failsafe LED indicator.
module rcfs_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [rcfs_pkg::CFG_IDX_BITS-1:0]  wr_index,
  input  logic [rcfs_pkg::CFG_DAT_BITS-1:0]  wr_data,
  output rcfs_pkg::cfg_t                     cfg
);
  import rcfs_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Decode the write request
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_e'(wr_index))
        REG_REPEAT_DELTA: cfg_nxt.repeat_delta = wr_data[DELTA_BITS-1:0];
        REG_ARM_THR:      cfg_nxt.arm_thr      = wr_data[SW_BITS-1:0];
        REG_OVR_THR:      cfg_nxt.ovr_thr      = wr_data[SW_BITS-1:0];
        REG_REPEAT_LIMIT: cfg_nxt.repeat_limit = wr_data[CNT_OUT_BITS-1:0];
        REG_INTERVAL:     cfg_nxt.interval     = wr_data[IVL_BITS-1:0];
        REG_FADE_STEP:    cfg_nxt.fade_step    = wr_data[LEVEL_BITS-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_delta <= RST_REPEAT_DELTA;
      cfg_r.arm_thr      <= RST_ARM_THR;
      cfg_r.ovr_thr      <= RST_OVR_THR;
      cfg_r.repeat_limit <= RST_REPEAT_LIMIT;
      cfg_r.interval     <= RST_INTERVAL;
      cfg_r.fade_step    <= RST_FADE_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/rcfs_core.sv
// LED mode, repeat counter and brightness state with their single-pass update.
module rcfs_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  rcfs_pkg::item_t item,
  input  rcfs_pkg::cfg_t  cfg,
  output rcfs_pkg::res_t  res
);
  import rcfs_pkg::*;

  typedef enum logic [3:0] {
    M_FADE_IN  = 4'b0001,
    M_FADE_OUT = 4'b0010,
    M_FAST     = 4'b0100,
    M_ON       = 4'b1000
  } mode_t;

  typedef logic [CHANNEL_BITS-1:0] stick_t;

  stick_t                  sticks_r   [NUM_STICKS];
  stick_t                  sticks_nxt [NUM_STICKS];
  stick_t                  cur        [NUM_STICKS];
  logic [COUNT_BITS-1:0]   cnt_r, cnt_nxt, cnt_inc;
  mode_t                   mode_r, mode_nxt, mode_led;
  logic [LEVEL_BITS-1:0]   level_r, level_nxt, level_led;
  logic [ELAPSED_BITS-1:0] el_r, el_nxt, el_inc;
  logic [NUM_STICKS-1:0]   near;
  logic                    keep_new;
  logic                    updated;
  logic [LEVEL_BITS:0]     fade_sum;
  logic [CHANNEL_BITS-1:0] diff [NUM_STICKS];
  logic [MODE_BITS-1:0]    mode_code;

  // Frame sticks at stored width
  assign cur[0] = CHANNEL_BITS'(item.aileron);
  assign cur[1] = CHANNEL_BITS'(item.elevator);
  assign cur[2] = CHANNEL_BITS'(item.throttle);
  assign cur[3] = CHANNEL_BITS'(item.rudder);

  // Per-stick repeat test against the kept frame
  always_comb begin
    for (int i = 0; i < NUM_STICKS; i++) begin
      diff[i] = (sticks_r[i] > cur[i]) ? sticks_r[i] - cur[i] : cur[i] - sticks_r[i];
      near[i] = diff[i] <= CHANNEL_BITS'(cfg.repeat_delta);
    end
  end

  assign cnt_inc  = cnt_r + COUNT_BITS'(1);
  assign el_inc   = (el_r < ELAPSED_MAX) ? el_r + ELAPSED_BITS'(1) : el_r;
  assign fade_sum = {1'b0, level_r} + {1'b0, cfg.fade_step};

  // One LED step
  always_comb begin
    mode_led  = mode_r;
    level_led = level_r;
    unique case (mode_r)
      M_FADE_IN: begin
        if (fade_sum > {1'b0, FULL_LEVEL}) mode_led = M_FADE_OUT;
        else level_led = fade_sum[LEVEL_BITS-1:0];
      end
      M_FADE_OUT: begin
        if (level_r < cfg.fade_step) mode_led = M_FADE_IN;
        else level_led = level_r - cfg.fade_step;
      end
      M_FAST:  level_led = (level_r != '0) ? '0 : FULL_LEVEL;
      default: level_led = FULL_LEVEL;
    endcase
  end

  // Next state for a frame or a tick
  always_comb begin
    mode_nxt  = mode_r;
    level_nxt = level_r;
    cnt_nxt   = cnt_r;
    el_nxt    = el_r;
    keep_new  = 1'b1;
    updated   = 1'b0;
    if (item.cmd == CMD_FRAME) begin
      if (item.arm_switch < cfg.arm_thr) begin
        if (mode_r != M_FADE_IN && mode_r != M_FADE_OUT) mode_nxt = M_FADE_IN;
      end else if (item.arm_switch > cfg.arm_thr) begin
        mode_nxt = M_ON;
        if (item.override_switch < cfg.ovr_thr && (&near)) begin
          keep_new = 1'b0;
          cnt_nxt  = cnt_inc;
          if (CMP_BITS'(cnt_inc) > CMP_BITS'(cfg.repeat_limit)) mode_nxt = M_FAST;
        end else begin
          cnt_nxt = '0;
        end
      end
    end else begin
      el_nxt = el_inc;
      if (el_inc > ELAPSED_BITS'(cfg.interval)) begin
        mode_nxt  = mode_led;
        level_nxt = level_led;
        el_nxt    = '0;
        updated   = 1'b1;
      end
    end
    for (int i = 0; i < NUM_STICKS; i++) begin
      sticks_nxt[i] = (item.cmd == CMD_FRAME && keep_new) ? cur[i] : sticks_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_FADE_IN;
      level_r <= '0;
      cnt_r   <= '0;
      el_r    <= '0;
      for (int i = 0; i < NUM_STICKS; i++) sticks_r[i] <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      level_r <= level_nxt;
      cnt_r   <= cnt_nxt;
      el_r    <= el_nxt;
      for (int i = 0; i < NUM_STICKS; i++) sticks_r[i] <= sticks_nxt[i];
    end
  end

  // Output mode code
  always_comb begin
    unique case (mode_nxt)
      M_FADE_IN:  mode_code = MODE_CODE_FADE_IN;
      M_FADE_OUT: mode_code = MODE_CODE_FADE_OUT;
      M_FAST:     mode_code = MODE_CODE_FAST;
      default:    mode_code = MODE_CODE_ON;
    endcase
  end

  assign res.led_level    = level_nxt;
  assign res.led_mode     = mode_code;
  assign res.repeat_count = CNT_OUT_BITS'(cnt_nxt);
  assign res.led_updated  = updated;

endmodule

FILE: rtl/rc_failsafe_led_indicator.sv
// Top level of the RC failsafe LED indicator: input register, core, result register.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   in_     | in_valid / in_stall  | cmd, four sticks, arm and override switches
//   out_    | out_valid / out_stall| led_level, led_mode, repeat_count, led_updated
//   cfg_    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item per clock sustained while out_stall stays low; an accepted item is held in the input
// register, then passes through the single-pass update into the result register.
// Reset (rst_n low, synchronous) empties both registers and loads default settings.
// in_stall rises only when the input register holds a request that cannot move
// because a result is waiting under out_stall. cfg_ready is always high.
module rc_failsafe_led_indicator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [rcfs_pkg::SW_BITS-1:0]        in_aileron,
  input  logic [rcfs_pkg::SW_BITS-1:0]        in_elevator,
  input  logic [rcfs_pkg::SW_BITS-1:0]        in_throttle,
  input  logic [rcfs_pkg::SW_BITS-1:0]        in_rudder,
  input  logic [rcfs_pkg::SW_BITS-1:0]        in_arm_switch,
  input  logic [rcfs_pkg::SW_BITS-1:0]        in_override_switch,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rcfs_pkg::LEVEL_BITS-1:0]     out_led_level,
  output logic [rcfs_pkg::MODE_BITS-1:0]      out_led_mode,
  output logic [rcfs_pkg::CNT_OUT_BITS-1:0]   out_repeat_count,
  output logic                                out_led_updated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcfs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rcfs_pkg::CFG_DAT_BITS-1:0]   cfg_data
);
  import rcfs_pkg::*;

  logic  in_vld_r, in_vld_nxt;
  item_t in_item_r;
  logic  out_vld_r, out_vld_nxt;
  res_t  out_res_r;
  logic  out_cmd_r;
  logic  adv, in_acc;
  cfg_t  cfg;
  res_t  res;

  // Configuration registers
  assign cfg_ready = 1'b1;

  rcfs_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Flow control
  assign adv      = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~adv;
  assign in_acc   = in_valid & ~in_stall;

  assign in_vld_nxt  = in_acc | (in_vld_r & ~adv);
  assign out_vld_nxt = adv | (out_vld_r & out_stall);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_item_r.cmd             <= in_cmd;
      in_item_r.aileron         <= in_aileron;
      in_item_r.elevator        <= in_elevator;
      in_item_r.throttle        <= in_throttle;
      in_item_r.rudder          <= in_rudder;
      in_item_r.arm_switch      <= in_arm_switch;
      in_item_r.override_switch <= in_override_switch;
    end
  end

  // Update logic
  rcfs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (adv),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= res;
      out_cmd_r <= in_item_r.cmd;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_led_level    = out_res_r.led_level;
  assign out_led_mode     = out_res_r.led_mode;
  assign out_repeat_count = out_res_r.repeat_count;
  assign out_led_updated  = out_res_r.led_updated;

`ifndef SYNTHESIS
  // A frame never reports an LED step
  a_frame_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.led_updated |-> out_cmd_r == CMD_TICK)
    else $error("LED update reported for a frame");

  // A held request moves on when the result register is free
  a_in_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !out_vld_r |=> out_vld_r)
    else $error("request stuck in input register");

  // Nothing is taken while both registers are full and the output is stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && out_vld_r && out_stall |-> in_stall)
    else $error("input accepted while pipeline blocked");

  // Registers come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_vld_r && !in_vld_r)
    else $error("valid set right after reset");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the RC failsafe LED indicator: directed and random requests.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rcfs_pkg::*;

  localparam int SW_MAX       = (1 << SW_BITS) - 1;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_REPEATS = 34;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_FIRST = REG_FADE_STEP + 1'b1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LAST  = '1;

  // Clock, reset and block inputs, all known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_cmd = CMD_TICK;
  logic [SW_BITS-1:0] in_aileron = '0;
  logic [SW_BITS-1:0] in_elevator = '0;
  logic [SW_BITS-1:0] in_throttle = '0;
  logic [SW_BITS-1:0] in_rudder = '0;
  logic [SW_BITS-1:0] in_arm_switch = '0;
  logic [SW_BITS-1:0] in_override_switch = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DAT_BITS-1:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  logic [LEVEL_BITS-1:0] out_led_level;
  logic [MODE_BITS-1:0] out_led_mode;
  logic [CNT_OUT_BITS-1:0] out_repeat_count;
  logic out_led_updated;
  logic cfg_ready;

  rc_failsafe_led_indicator u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_cmd             (in_cmd),
    .in_aileron         (in_aileron),
    .in_elevator        (in_elevator),
    .in_throttle        (in_throttle),
    .in_rudder          (in_rudder),
    .in_arm_switch      (in_arm_switch),
    .in_override_switch (in_override_switch),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_led_level      (out_led_level),
    .out_led_mode       (out_led_mode),
    .out_repeat_count   (out_repeat_count),
    .out_led_updated    (out_led_updated),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #1 clk = ~clk;

  // Settings as the indicator should hold them
  logic [DELTA_BITS-1:0]   set_delta    = RST_REPEAT_DELTA;
  logic [SW_BITS-1:0]      set_arm_thr  = RST_ARM_THR;
  logic [SW_BITS-1:0]      set_ovr_thr  = RST_OVR_THR;
  logic [CNT_OUT_BITS-1:0] set_limit    = RST_REPEAT_LIMIT;
  logic [IVL_BITS-1:0]     set_interval = RST_INTERVAL;
  logic [LEVEL_BITS-1:0]   set_step     = RST_FADE_STEP;

  // Indicator state as predicted
  logic [CHANNEL_BITS-1:0] kept_sticks [NUM_STICKS] = '{default: '0};
  logic [COUNT_BITS-1:0]   repeat_ctr  = '0;
  logic [MODE_BITS-1:0]    led_mode    = MODE_CODE_FADE_IN;
  logic [LEVEL_BITS-1:0]   led_level   = '0;
  logic [ELAPSED_BITS-1:0] elapsed_ms  = '0;

  res_t led_state_q [$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   burst_left = 0;

  // Work out the LED state that one request leaves behind
  task automatic advance_indicator(input item_t it, output res_t r);
    logic [CHANNEL_BITS-1:0] cur [NUM_STICKS];
    bit keep_new;
    bit all_near;
    int d;
    cur[0] = it.aileron;
    cur[1] = it.elevator;
    cur[2] = it.throttle;
    cur[3] = it.rudder;
    keep_new = 1'b1;
    r.led_updated = 1'b0;
    if (it.cmd == CMD_FRAME) begin
      if (it.arm_switch < set_arm_thr) begin
        if (led_mode != MODE_CODE_FADE_IN && led_mode != MODE_CODE_FADE_OUT)
          led_mode = MODE_CODE_FADE_IN;
      end else if (it.arm_switch > set_arm_thr) begin
        led_mode = MODE_CODE_ON;
        if (it.override_switch < set_ovr_thr) begin
          all_near = 1'b1;
          for (int i = 0; i < NUM_STICKS; i++) begin
            d = int'(kept_sticks[i]) - int'(cur[i]);
            if (d < 0) d = -d;
            if (d > int'(set_delta)) all_near = 1'b0;
          end
          if (all_near) begin
            // repeated command: count it, keep the old sticks
            keep_new = 1'b0;
            repeat_ctr = repeat_ctr + 1'b1;
            if (repeat_ctr > set_limit) led_mode = MODE_CODE_FAST;
          end else begin
            repeat_ctr = '0;
          end
        end else begin
          repeat_ctr = '0;
        end
      end
      if (keep_new) kept_sticks = cur;
    end else begin
      if (elapsed_ms < ELAPSED_MAX) elapsed_ms = elapsed_ms + 1'b1;
      if (elapsed_ms > set_interval) begin
        case (led_mode)
          MODE_CODE_FADE_IN: begin
            if (int'(led_level) + int'(set_step) > int'(FULL_LEVEL)) led_mode = MODE_CODE_FADE_OUT;
            else led_level = led_level + set_step;
          end
          MODE_CODE_FADE_OUT: begin
            if (led_level < set_step) led_mode = MODE_CODE_FADE_IN;
            else led_level = led_level - set_step;
          end
          MODE_CODE_FAST: led_level = (led_level != '0) ? '0 : FULL_LEVEL;
          default: led_level = FULL_LEVEL;
        endcase
        elapsed_ms = '0;
        r.led_updated = 1'b1;
      end
    end
    r.led_level = led_level;
    r.led_mode = led_mode;
    r.repeat_count = CNT_OUT_BITS'(repeat_ctr);
  endtask

  // Send one request in bursts with random gaps; predict once accepted
  task automatic send_request(input item_t it);
    res_t r;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    in_valid <= 1'b1;
    in_cmd <= it.cmd;
    in_aileron <= it.aileron;
    in_elevator <= it.elevator;
    in_throttle <= it.throttle;
    in_rudder <= it.rudder;
    in_arm_switch <= it.arm_switch;
    in_override_switch <= it.override_switch;
    do @(posedge clk); while (in_stall);
    burst_left--;
    advance_indicator(it, r);
    led_state_q.push_back(r);
  endtask

  // Hold off the sender until every expected result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (led_state_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write; caller lowers cfg_valid after a batch
  task automatic write_setting(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DAT_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_REPEAT_DELTA: set_delta = data[DELTA_BITS-1:0];
      REG_ARM_THR:      set_arm_thr = data[SW_BITS-1:0];
      REG_OVR_THR:      set_ovr_thr = data[SW_BITS-1:0];
      REG_REPEAT_LIMIT: set_limit = data[CNT_OUT_BITS-1:0];
      REG_INTERVAL:     set_interval = data[IVL_BITS-1:0];
      REG_FADE_STEP:    set_step = data[LEVEL_BITS-1:0];
      default: ;
    endcase
  endtask

  // Drain, then write every register (junk in the unused upper bits) and both spare indexes
  task automatic apply_settings(input logic [DELTA_BITS-1:0] delta,
                                input logic [SW_BITS-1:0] arm_thr,
                                input logic [SW_BITS-1:0] ovr_thr,
                                input logic [CNT_OUT_BITS-1:0] limit,
                                input logic [IVL_BITS-1:0] interval,
                                input logic [LEVEL_BITS-1:0] step);
    drain_results();
    write_setting(REG_SPARE_FIRST, CFG_DAT_BITS'($urandom));
    write_setting(REG_REPEAT_DELTA, {8'($urandom), delta});
    write_setting(REG_ARM_THR, {4'($urandom), arm_thr});
    write_setting(REG_OVR_THR, {4'($urandom), ovr_thr});
    write_setting(REG_REPEAT_LIMIT, limit);
    write_setting(REG_INTERVAL, {6'($urandom), interval});
    write_setting(REG_FADE_STEP, {8'($urandom), step});
    write_setting(REG_SPARE_LAST, CFG_DAT_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic item_t make_frame(int ail, int ele, int thr, int rud, int arm, int ovr);
    item_t it;
    it.cmd = CMD_FRAME;
    it.aileron = SW_BITS'(ail);
    it.elevator = SW_BITS'(ele);
    it.throttle = SW_BITS'(thr);
    it.rudder = SW_BITS'(rud);
    it.arm_switch = SW_BITS'(arm);
    it.override_switch = SW_BITS'(ovr);
    return it;
  endfunction

  function automatic item_t random_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t make_tick();
    item_t it;
    it = random_item();
    it.cmd = CMD_TICK;
    return it;
  endfunction

  function automatic int clamp_sw(int v);
    return (v < 0) ? 0 : (v > SW_MAX) ? SW_MAX : v;
  endfunction

  // A stick value close to the kept one, sometimes just past the delta
  function automatic int near_value(logic [CHANNEL_BITS-1:0] base);
    int span;
    span = int'(set_delta) + 2;
    return clamp_sw(int'(base) + int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Switch value around a threshold or anywhere
  function automatic int pick_switch(logic [SW_BITS-1:0] thr);
    case ($urandom_range(0, 4))
      0: return clamp_sw(int'(thr) - 1);
      1: return int'(thr);
      2: return clamp_sw(int'(thr) + 1);
      default: return int'($urandom_range(0, SW_MAX));
    endcase
  endfunction

  // Arm decisions, override repeats and fast blink with a small limit
  task automatic test_frame_decisions();
    apply_settings(8'd5, 12'd1250, 12'd1250, 16'd2, 10'd0, 8'd5);
    send_request(make_tick());
    send_request(make_frame(0, 0, 0, 0, 0, 0));
    send_request(make_frame(SW_MAX, SW_MAX, SW_MAX, SW_MAX, SW_MAX, SW_MAX));
    send_request(make_tick());
    // arm exactly at the threshold
    send_request(make_frame(100, 100, 100, 100, 1250, 0));
    send_request(make_frame(105, 95, 100, 100, 1251, 1249));
    // one stick just past the delta
    send_request(make_frame(106, 100, 100, 100, SW_MAX, 0));
    repeat (3) send_request(make_frame(106, 100, 100, 100, SW_MAX, 0));
    send_request(make_tick());
    send_request(make_tick());
    send_request(make_frame(106, 100, 100, 100, 1249, 0));
    send_request(make_tick());
    send_request(make_tick());
    send_request(make_frame(0, 0, 0, 0, 0, 0));
    // override exactly at its threshold is inactive
    send_request(make_frame(0, 0, 0, 0, 1251, 1250));
  endtask

  // Fade with the largest, zero and smallest step
  task automatic test_fade_extremes();
    apply_settings(8'd5, 12'd1250, 12'd1250, 16'd2, 10'd0, 8'd255);
    send_request(make_frame(0, 0, 0, 0, 0, 0));
    repeat (4) send_request(make_tick());
    apply_settings(8'd5, 12'd1250, 12'd1250, 16'd2, 10'd0, 8'd0);
    repeat (3) send_request(make_tick());
    apply_settings(8'd5, 12'd1250, 12'd1250, 16'd2, 10'd1, 8'd1);
    repeat (4) send_request(make_tick());
  endtask

  // Repeat counter climbs past a small limit, then a zero limit forces fast blink
  task automatic test_counter_limit();
    apply_settings(8'd0, 12'd1000, 12'd3000, 16'd30, 10'd0, 8'd5);
    send_request(make_frame(1500, 1501, 1502, 1503, 2000, 100));
    repeat (LIMIT_REPEATS) send_request(make_frame(1500, 1501, 1502, 1503, 2000, 100));
    repeat (3) send_request(make_tick());
    apply_settings(8'd0, 12'd1000, 12'd3000, 16'd0, 10'd0, 8'd5);
    send_request(make_frame(1500, 1501, 1502, 1503, 2000, 100));
    repeat (3) send_request(make_tick());
  endtask

  // Mostly armed frames under override near the kept sticks, plus ticks and noise
  task automatic run_random_items(input int n, input bit pause_midway);
    item_t it;
    int pick;
    int arm;
    int ovr;
    for (int k = 0; k < n; k++) begin
      if (pause_midway && k == n / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        it = make_tick();
      end else if (pick < 80) begin
        if ($urandom_range(0, 9) < 7 && set_arm_thr < SW_MAX)
          arm = $urandom_range(int'(set_arm_thr) + 1, SW_MAX);
        else
          arm = pick_switch(set_arm_thr);
        if ($urandom_range(0, 9) < 8 && set_ovr_thr > 0)
          ovr = $urandom_range(0, int'(set_ovr_thr) - 1);
        else
          ovr = pick_switch(set_ovr_thr);
        it = make_frame(near_value(kept_sticks[0]), near_value(kept_sticks[1]),
                        near_value(kept_sticks[2]), near_value(kept_sticks[3]), arm, ovr);
      end else begin
        it = random_item();
      end
      send_request(it);
    end
  endtask

  task automatic test_random_traffic();
    apply_settings(8'd5, 12'd1250, 12'd1250, 16'd50, 10'd3, 8'd5);
    run_random_items(320, 1'b1);
    apply_settings(8'd0, 12'd0, 12'hFFF, 16'd0, 10'd0, 8'd255);
    run_random_items(320, 1'b0);
    apply_settings(8'd255, 12'hFFF, 12'd0, 16'hFFFF, 10'd1023, 8'd1);
    run_random_items(320, 1'b0);
    apply_settings(DELTA_BITS'($urandom), SW_BITS'($urandom), SW_BITS'($urandom),
                   CNT_OUT_BITS'($urandom_range(0, 40)), IVL_BITS'($urandom_range(0, 7)),
                   LEVEL_BITS'($urandom_range(1, 255)));
    run_random_items(320, 1'b0);
    apply_settings(RST_REPEAT_DELTA, RST_ARM_THR, RST_OVR_THR, RST_REPEAT_LIMIT,
                   RST_INTERVAL, RST_FADE_STEP);
    run_random_items(320, 1'b0);
  endtask

  // Result side stalls in patterns that change whenever the 8-bit stall_age counter wraps
  logic [7:0] stall_age = '0;
  logic [1:0] stall_kind = '0;
  always @(posedge clk) begin
    stall_age <= stall_age + 1'b1;
    if (stall_age == '0) stall_kind <= 2'($urandom_range(0, 3));
    case (stall_kind)
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= 1'($urandom_range(0, 1));
      default: out_stall <= (stall_age[2:0] < 3'd3);
    endcase
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (led_state_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: unexpected, level %0d mode %0d count %0d updated %0b",
                   results_seen, out_led_level, out_led_mode, out_repeat_count,
                   out_led_updated);
      end else begin
        want = led_state_q.pop_front();
        if (out_led_level !== want.led_level || out_led_mode !== want.led_mode ||
            out_repeat_count !== want.repeat_count ||
            out_led_updated !== want.led_updated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected level %0d mode %0d count %0d updated %0b, got level %0d mode %0d count %0d updated %0b",
                     results_seen, want.led_level, want.led_mode, want.repeat_count,
                     want.led_updated, out_led_level, out_led_mode, out_repeat_count,
                     out_led_updated);
        end
      end
    end
  end

  // Cycle limit
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_frame_decisions();
    test_fade_extremes();
    test_counter_limit();
    test_random_traffic();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
